@@ src/fpa_pkg.sv @@
// Shared widths, constants, item type and scaling function for the atan2 unit.
package fpa_pkg;

  localparam int COORD_BITS   = 13;
  localparam int COORD_SCALE  = 1000;
  localparam int RATIO_SCALE  = 100;
  localparam int COEF_QUARTER = 78;
  localparam int COEF_THREE_Q = 235;
  localparam int ANGLE_W      = 10;

  // |y|*1000 + 1 and |x|*1000
  localparam int MAG_W = $clog2((2 ** (COORD_BITS - 1)) * COORD_SCALE + 2);
  localparam int XS_W  = MAG_W + 1;
  localparam int DEN_W = MAG_W + 1;
  localparam int SUM_W = DEN_W + 1;
  // quotient never exceeds RATIO_SCALE
  localparam int Q_W   = $clog2(RATIO_SCALE + 1);
  localparam int REM_W = DEN_W + Q_W;

  // floor(q * 78 / 100) as a multiply by a rounded-up reciprocal, exact for q <= 100
  localparam int SCALE_SHIFT = 19;
  localparam int SCALE_MUL   = (COEF_QUARTER * (2 ** SCALE_SHIFT) + RATIO_SCALE - 1) / RATIO_SCALE;
  localparam int SCALE_MUL_W = $clog2(SCALE_MUL + 1);
  localparam int PROD_W      = Q_W + SCALE_MUL_W;

  typedef struct packed {
    logic [REM_W-1:0] num_scaled;
    logic [DEN_W-1:0] den;
    logic             rneg;
    logic             xneg;
    logic             yneg;
  } fpa_item_t;

  function automatic logic [Q_W-1:0] scale_quarter(input logic [Q_W-1:0] q);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(q) * PROD_W'(SCALE_MUL);
    return Q_W'(prod >> SCALE_SHIFT);
  endfunction

endpackage

@@ src/fixed_point_atan2_unit.sv @@
// Top level of the fixed-point atan2 unit.
// Computes an approximate atan2(y, x) in hundredths of a radian, one coordinate
// pair per clock: a transaction is taken whenever start is high and busy is low,
// and busy stays low in normal operation because the divider pipeline drains its
// queue every cycle. Each angle appears on out_angle_centirad for one cycle with
// out_valid high, having passed twelve registers (two front stages, one queue
// slot, a divider input stage, seven divider stages, one mapping stage); the
// receiver cannot stall.
module fixed_point_atan2_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [fpa_pkg::COORD_BITS-1:0] in_y_coord,
  input  logic signed [fpa_pkg::COORD_BITS-1:0] in_x_coord,
  output logic                                 out_valid,
  output logic signed [fpa_pkg::ANGLE_W-1:0]   out_angle_centirad
);

  logic               take;
  logic               push;
  logic               pop;
  logic               full;
  fpa_pkg::fpa_item_t push_item;
  fpa_pkg::fpa_item_t pop_item;

  assign busy = full;
  assign take = start && !full;

  fpa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .y_coord (in_y_coord),
    .x_coord (in_x_coord),
    .push    (push),
    .item    (push_item)
  );

  fpa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (full)
  );

  fpa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (pop),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_angle (out_angle_centirad)
  );

endmodule

@@ src/fpa_front.sv @@
// Front end: scale coordinates, classify the half plane, form numerator and divisor.
module fpa_front (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     take,
  input  logic signed [fpa_pkg::COORD_BITS-1:0]    y_coord,
  input  logic signed [fpa_pkg::COORD_BITS-1:0]    x_coord,
  output logic                                     push,
  output fpa_pkg::fpa_item_t                       item
);

  localparam logic signed [fpa_pkg::XS_W-1:0] XSCALE = fpa_pkg::XS_W'(fpa_pkg::COORD_SCALE);

  logic                              va_r;
  logic                              vb_r;
  logic signed [fpa_pkg::XS_W-1:0]   xs_r;
  logic [fpa_pkg::MAG_W-1:0]         ay_r;
  logic                              xneg_a_r;
  logic                              yneg_a_r;
  fpa_pkg::fpa_item_t                item_r;

  logic [fpa_pkg::COORD_BITS-1:0]    ymag;
  logic signed [fpa_pkg::XS_W-1:0]   x_ext;
  logic signed [fpa_pkg::XS_W-1:0]   xs_nxt;
  logic [fpa_pkg::MAG_W-1:0]         ay_nxt;

  logic signed [fpa_pkg::SUM_W-1:0]  xs_w;
  logic signed [fpa_pkg::SUM_W-1:0]  ay_w;
  logic signed [fpa_pkg::SUM_W-1:0]  num;
  logic signed [fpa_pkg::SUM_W-1:0]  den;
  logic [fpa_pkg::SUM_W-1:0]         nabs;
  fpa_pkg::fpa_item_t                item_nxt;

  // stage A: scale by 1000
  always_comb begin
    ymag   = y_coord[fpa_pkg::COORD_BITS-1] ? (~y_coord + 1'b1) : y_coord;
    x_ext  = fpa_pkg::XS_W'(x_coord);
    xs_nxt = x_ext * XSCALE;
    ay_nxt = fpa_pkg::MAG_W'(ymag) * fpa_pkg::MAG_W'(fpa_pkg::COORD_SCALE)
             + fpa_pkg::MAG_W'(1);
  end

  // stage B: pick numerator and divisor by the sign of x
  always_comb begin
    xs_w = fpa_pkg::SUM_W'(xs_r);
    ay_w = signed'(fpa_pkg::SUM_W'(ay_r));
    if (xneg_a_r) begin
      num = xs_w + ay_w;
      den = ay_w - xs_w;
    end else begin
      num = xs_w - ay_w;
      den = xs_w + ay_w;
    end
    nabs = num[fpa_pkg::SUM_W-1] ? unsigned'(-num) : unsigned'(num);
    item_nxt.num_scaled = fpa_pkg::REM_W'(nabs[fpa_pkg::DEN_W-1:0])
                          * fpa_pkg::REM_W'(fpa_pkg::RATIO_SCALE);
    item_nxt.den  = den[fpa_pkg::DEN_W-1:0];
    item_nxt.rneg = num[fpa_pkg::SUM_W-1];
    item_nxt.xneg = xneg_a_r;
    item_nxt.yneg = yneg_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= take;
      vb_r <= va_r;
    end
    xs_r     <= xs_nxt;
    ay_r     <= ay_nxt;
    xneg_a_r <= x_coord[fpa_pkg::COORD_BITS-1];
    yneg_a_r <= y_coord[fpa_pkg::COORD_BITS-1];
    item_r   <= item_nxt;
  end

  assign push = vb_r;
  assign item = item_r;

endmodule

@@ src/fpa_queue.sv @@
// Two-entry queue between the front end and the divider pipeline.
module fpa_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fpa_pkg::fpa_item_t push_item,
  output logic               pop,
  output fpa_pkg::fpa_item_t pop_item,
  output logic               full
);

  fpa_pkg::fpa_item_t mem_r [2];
  logic               wptr_r;
  logic               rptr_r;
  logic [1:0]         cnt_r;
  logic [1:0]         cnt_nxt;

  // the divider never stalls, so drain whenever something is held
  assign pop      = (cnt_r != 2'd0);
  assign pop_item = mem_r[rptr_r];
  assign full     = (cnt_r == 2'd2);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wptr_r] <= push_item;
  end

endmodule

@@ src/fpa_back.sv @@
// Back end: pipelined restoring divider, one quotient bit per stage, then angle mapping.
module fpa_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  pop,
  input  fpa_pkg::fpa_item_t                    pop_item,
  output logic                                  out_valid,
  output logic signed [fpa_pkg::ANGLE_W-1:0]    out_angle
);

  localparam int NST = fpa_pkg::Q_W;

  logic                        v_r    [NST+1];
  logic [fpa_pkg::REM_W-1:0]   rem_r  [NST+1];
  logic [fpa_pkg::DEN_W-1:0]   den_r  [NST+1];
  logic [fpa_pkg::Q_W-1:0]     q_r    [NST+1];
  logic                        rneg_r [NST+1];
  logic                        xneg_r [NST+1];
  logic                        yneg_r [NST+1];

  logic [fpa_pkg::REM_W-1:0]   rem_nxt [NST];
  logic [fpa_pkg::Q_W-1:0]     q_nxt   [NST];

  logic                               vout_r;
  logic signed [fpa_pkg::ANGLE_W-1:0] angle_r;

  logic [fpa_pkg::Q_W-1:0]            t_mag;
  logic signed [fpa_pkg::ANGLE_W-1:0] t_s;
  logic signed [fpa_pkg::ANGLE_W-1:0] base;
  logic signed [fpa_pkg::ANGLE_W-1:0] ang;

  // each stage tries the divisor shifted to its own quotient bit
  always_comb begin
    for (int k = 0; k < NST; k++) begin
      logic [fpa_pkg::REM_W-1:0] dsh;
      dsh = fpa_pkg::REM_W'(den_r[k]) << (NST - 1 - k);
      rem_nxt[k] = rem_r[k];
      q_nxt[k]   = q_r[k];
      if (rem_r[k] >= dsh) begin
        rem_nxt[k]             = rem_r[k] - dsh;
        q_nxt[k][NST - 1 - k]  = 1'b1;
      end
    end
  end

  // angle = base - trunc(78*r/100), negated below the x axis
  always_comb begin
    t_mag = fpa_pkg::scale_quarter(q_r[NST]);
    t_s   = fpa_pkg::ANGLE_W'(t_mag);
    if (rneg_r[NST]) t_s = -t_s;
    base  = xneg_r[NST] ? fpa_pkg::ANGLE_W'(fpa_pkg::COEF_THREE_Q)
                        : fpa_pkg::ANGLE_W'(fpa_pkg::COEF_QUARTER);
    ang   = base - t_s;
    if (yneg_r[NST]) ang = -ang;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NST; k++) v_r[k] <= 1'b0;
      vout_r <= 1'b0;
    end else begin
      v_r[0] <= pop;
      for (int k = 0; k < NST; k++) v_r[k+1] <= v_r[k];
      vout_r <= v_r[NST];
    end
    rem_r[0]  <= pop_item.num_scaled;
    den_r[0]  <= pop_item.den;
    q_r[0]    <= '0;
    rneg_r[0] <= pop_item.rneg;
    xneg_r[0] <= pop_item.xneg;
    yneg_r[0] <= pop_item.yneg;
    for (int k = 0; k < NST; k++) begin
      rem_r[k+1]  <= rem_nxt[k];
      den_r[k+1]  <= den_r[k];
      q_r[k+1]    <= q_nxt[k];
      rneg_r[k+1] <= rneg_r[k];
      xneg_r[k+1] <= xneg_r[k];
      yneg_r[k+1] <= yneg_r[k];
    end
    angle_r <= ang;
  end

  assign out_valid = vout_r;
  assign out_angle = angle_r;

endmodule
